[src/tkm_pkg.sv]
package tkm_pkg;

  localparam int IDENT_W = 16;
  localparam int SCORE_W = 32;
  localparam int CFG_W   = 4;

  localparam int TOP_DEPTH_DEF  = 8;
  localparam int MAX_IDENTS_DEF = 65536;

  localparam logic [CFG_W-1:0] SHOWN_RESET = CFG_W'(8);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [IDENT_W-1:0] ident;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic               ins_en;
    logic [IDENT_W-1:0] ins_ident;
    logic [SCORE_W-1:0] ins_score;
    logic [IDENT_W-1:0] qry_ident;
  } cell_ctl_t;

  typedef struct packed {
    logic take;
    logic dup;
    logic match;
  } cell_stat_t;

endpackage

[src/tkm_cell.sv]
module tkm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tkm_pkg::cell_ctl_t ctl,
  input  tkm_pkg::entry_t    prev_entry,
  input  logic               prev_take,
  output tkm_pkg::entry_t    entry,
  output tkm_pkg::cell_stat_t stat
);

  logic                        valid_r;
  logic [tkm_pkg::IDENT_W-1:0] ident_r;
  logic [tkm_pkg::SCORE_W-1:0] score_r;
  logic                        above;

  assign above = (ctl.ins_score > score_r) ||
                 ((ctl.ins_score == score_r) && (ctl.ins_ident > ident_r));

  // new pair belongs here or further up the row
  assign stat.take  = !valid_r || above;
  assign stat.dup   = valid_r && (ctl.ins_score == score_r) && (ctl.ins_ident == ident_r);
  assign stat.match = valid_r && (ident_r == ctl.qry_ident);

  assign entry.valid = valid_r;
  assign entry.ident = ident_r;
  assign entry.score = score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.ins_en) begin
      if (prev_take) begin
        valid_r <= prev_entry.valid;
      end else if (stat.take) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (prev_take) begin
        ident_r <= prev_entry.ident;
        score_r <= prev_entry.score;
      end else if (stat.take) begin
        ident_r <= ctl.ins_ident;
        score_r <= ctl.ins_score;
      end
    end
  end

endmodule

[src/top_k_membership_tracker.sv]
// Top-k membership tracker. A row of TOP_DEPTH cells holds the best (score, ident)
// pairs seen so far, best first, ties going to the larger ident. An insert word
// (op 0) is compared against every cell at once and the row shifts by one cell
// behind the insertion point in the same cycle; a pair already stored, a pair below
// a full row or an ident at or above MAX_IDENTS leaves the row unchanged. A query
// word (op 1) compares its ident against the first min(shown_count, TOP_DEPTH)
// cells and returns in_top in the next cycle from an output register. One word is
// accepted per cycle; the input stalls only while a query result sits in the
// output register and the output side stalls. Reset empties the row.
module top_k_membership_tracker #(
  parameter int TOP_DEPTH  = tkm_pkg::TOP_DEPTH_DEF,
  parameter int MAX_IDENTS = tkm_pkg::MAX_IDENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tkm_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [tkm_pkg::IDENT_W-1:0] in_ident,
  input  logic [tkm_pkg::SCORE_W-1:0] in_score,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_in_top
);

  logic [tkm_pkg::CFG_W-1:0] shown_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_in_top_r, out_in_top_nxt;

  logic                in_fire;
  logic                id_ok;
  logic                any_dup;
  logic                hit;
  tkm_pkg::cell_ctl_t  ctl;

  tkm_pkg::entry_t     cell_entry [TOP_DEPTH];
  tkm_pkg::entry_t     prev_entry [TOP_DEPTH];
  tkm_pkg::cell_stat_t cell_stat  [TOP_DEPTH];
  logic [TOP_DEPTH-1:0] prev_take;
  logic [TOP_DEPTH-1:0] dup_vec;
  logic [TOP_DEPTH-1:0] match_vec;
  logic [TOP_DEPTH-1:0] shown_vec;
  logic [TOP_DEPTH-1:0] valid_vec;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign id_ok    = 32'(in_ident) < 32'(MAX_IDENTS);

  assign any_dup = |dup_vec;
  assign hit     = |(match_vec & shown_vec);

  assign ctl.ins_en    = in_fire && (in_op == tkm_pkg::OP_INSERT) && id_ok && !any_dup;
  assign ctl.ins_ident = in_ident;
  assign ctl.ins_score = in_score;
  assign ctl.qry_ident = in_ident;

  genvar i;
  generate
    for (i = 0; i < TOP_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_entry[i] = '0;
        assign prev_take[i]  = 1'b0;
      end else begin : g_link
        assign prev_entry[i] = cell_entry[i-1];
        assign prev_take[i]  = cell_stat[i-1].take;
      end

      assign dup_vec[i]   = cell_stat[i].dup;
      assign match_vec[i] = cell_stat[i].match;
      assign shown_vec[i] = 32'(i) < 32'(shown_r);
      assign valid_vec[i] = cell_entry[i].valid;

      tkm_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_entry (prev_entry[i]),
        .prev_take  (prev_take[i]),
        .entry      (cell_entry[i]),
        .stat       (cell_stat[i])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_in_top_nxt = out_in_top_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && (in_op == tkm_pkg::OP_QUERY)) begin
      out_valid_nxt  = 1'b1;
      out_in_top_nxt = id_ok && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= tkm_pkg::SHOWN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        shown_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_in_top_r <= out_in_top_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_in_top = out_in_top_r;

  // a valid insert always leaves the best cell occupied
  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == tkm_pkg::OP_INSERT) && id_ok |=> valid_vec[0])
    else $error("head cell empty after insert");

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == tkm_pkg::OP_QUERY) |=> out_valid_r)
    else $error("query produced no result");

  a_no_dup_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && any_dup |=> $stable(valid_vec))
    else $error("row changed on duplicate insert");

  generate
    for (i = 1; i < TOP_DEPTH; i++) begin : g_chk
      a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[i] |-> valid_vec[i-1])
        else $error("gap in occupied cells");
    end
  endgenerate

endmodule
